### rtl/terminal_escape_sequence_framer_defines.svh
// assertion macros shared by the framer modules
// depends on nothing; taken in by the files that carry assertions
`ifndef TERMINAL_ESCAPE_SEQUENCE_FRAMER_DEFINES_SVH
`define TERMINAL_ESCAPE_SEQUENCE_FRAMER_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define TESF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define TESF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/tesf_pkg.sv
// types, codes and helpers of the terminal escape sequence framer
// no dependencies; imported by every framer module
package tesf_pkg;

   localparam int SEQ_DEPTH_DEFAULT = 32;

   // input operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // sequence kind codes
   localparam logic [2:0] KIND_RAW = 3'd0;
   localparam logic [2:0] KIND_ESC = 3'd1;
   localparam logic [2:0] KIND_CSI = 3'd2;
   localparam logic [2:0] KIND_SS3 = 3'd3;
   localparam logic [2:0] KIND_OSC = 3'd4;
   localparam logic [2:0] KIND_DCS = 3'd5;
   localparam logic [2:0] KIND_OVF = 3'd6;

   // special bytes
   localparam logic [7:0] BYTE_ESC       = 8'h1B;
   localparam logic [7:0] BYTE_BEL       = 8'h07;
   localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
   localparam logic [7:0] BYTE_FINAL_HI  = 8'h7E;
   localparam logic [7:0] BYTE_CSI_INTRO = 8'h5B;   // '['
   localparam logic [7:0] BYTE_SS3_INTRO = 8'h4F;   // 'O'
   localparam logic [7:0] BYTE_OSC_INTRO = 8'h5D;   // ']'
   localparam logic [7:0] BYTE_DCS_INTRO = 8'h50;   // 'P'
   localparam logic [7:0] BYTE_BSLASH    = 8'h5C;   // '\'

   localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

   // parser mode, one-hot
   typedef enum logic [6:0] {
      MODE_IDLE = 7'b0000001,
      MODE_UTF8 = 7'b0000010,
      MODE_ESC  = 7'b0000100,
      MODE_CSI  = 7'b0001000,
      MODE_SS3  = 7'b0010000,
      MODE_OSC  = 7'b0100000,
      MODE_DCS  = 7'b1000000
   } mode_type;

   // controller state, one-hot
   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic take;   // input transfer this cycle
      logic load;   // read next stored byte into the output register
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic flush_req;    // the current input item completes a sequence
      logic out_busy;     // output register holds a byte that is stalled
      logic drain_last;   // the read pointer is at the last byte
   } dp_status_type;

   // utf-8 sequence length from its lead byte, 1 for anything else
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd1;
      if (b >= 8'hC2 && b <= 8'hDF) n = 3'd2;
      else if (b >= 8'hE0 && b <= 8'hEF) n = 3'd3;
      else if (b >= 8'hF0 && b <= 8'hF4) n = 3'd4;
      return n;
   endfunction

endpackage

### rtl/tesf_ctrl.sv
// controller of the framer: input handshake and readout sequencing
// depends on tesf_pkg and the framer assertion macros
`include "terminal_escape_sequence_framer_defines.svh"

module tesf_ctrl
   import tesf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   // handshake and commands
   always_comb begin
      req_stall = (state_ff != ST_RUN);
      cmd.take  = req_valid && (state_ff == ST_RUN);
      cmd.load  = (state_ff == ST_DRAIN) && !status.out_busy;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.take && status.flush_req) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (cmd.load && status.drain_last) state_in = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   `TESF_ASSERT_NEXT(a_flush_starts_drain, clock, reset, cmd.take && status.flush_req, state_ff == ST_DRAIN, "completed sequence did not start readout")

endmodule

### rtl/tesf_datapath.sv
// datapath of the framer: sequence store, parser state, readout and output register
// depends on tesf_pkg and the framer assertion macros
`include "terminal_escape_sequence_framer_defines.svh"

module tesf_datapath
   import tesf_pkg::*;
#(
   parameter int SEQ_DEPTH = SEQ_DEPTH_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_op,
   input  logic [7:0]    req_data_byte,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_seq_byte,
   output logic [2:0]    rsp_seq_kind,
   output logic          rsp_last_of_seq,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam int LW = $clog2(SEQ_DEPTH + 1);
   localparam logic [LW-1:0] DEPTH_L = LW'(SEQ_DEPTH);

   logic [7:0]    store_mem [SEQ_DEPTH];

   logic [15:0]   timeout_ff;
   logic [LW-1:0] length_ff, length_in;
   mode_type      mode_ff, mode_in;
   logic [2:0]    utf8_len_ff, utf8_len_in;
   logic [16:0]   elapsed_ff, elapsed_in;
   logic          pending_ff, pending_in;

   logic [LW-1:0] drain_len_ff;
   logic [AW-1:0] rd_ptr_ff;
   logic [2:0]    kind_ff;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic [2:0]    rsp_kind_ff;
   logic          rsp_last_ff;

   logic [LW-1:0] len_inc;
   logic [16:0]   elapsed_inc;
   logic [2:0]    lead_n;
   logic          flush;
   logic [2:0]    flush_kind;

   assign len_inc     = length_ff + LW'(1);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 17'd1;
   assign lead_n      = lead_length(req_data_byte);

   // parser: next state and completion of the current item
   always_comb begin
      length_in   = length_ff;
      mode_in     = mode_ff;
      utf8_len_in = utf8_len_ff;
      elapsed_in  = elapsed_ff;
      pending_in  = pending_ff;
      flush       = 1'b0;
      flush_kind  = KIND_RAW;
      if (req_op == OP_TICK) begin
         if (mode_ff == MODE_ESC) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc > {1'b0, timeout_ff}) begin
               flush      = 1'b1;
               flush_kind = KIND_ESC;
            end
         end
      end else begin
         length_in = len_inc;
         unique case (mode_ff) inside
            MODE_IDLE: begin
               if (req_data_byte == BYTE_ESC) begin
                  if (timeout_ff == 16'd0) begin
                     flush      = 1'b1;
                     flush_kind = KIND_ESC;
                  end else begin
                     mode_in    = MODE_ESC;
                     elapsed_in = 17'd0;
                  end
               end else if (lead_n == 3'd1) begin
                  flush      = 1'b1;
                  flush_kind = KIND_RAW;
               end else begin
                  mode_in     = MODE_UTF8;
                  utf8_len_in = lead_n;
               end
            end
            MODE_UTF8: begin
               if (len_inc >= LW'(utf8_len_ff)) begin
                  flush      = 1'b1;
                  flush_kind = KIND_RAW;
               end
            end
            MODE_ESC: begin
               elapsed_in = 17'd0;
               pending_in = 1'b0;
               unique case (req_data_byte)
                  BYTE_CSI_INTRO: mode_in = MODE_CSI;
                  BYTE_SS3_INTRO: mode_in = MODE_SS3;
                  BYTE_OSC_INTRO: mode_in = MODE_OSC;
                  BYTE_DCS_INTRO: mode_in = MODE_DCS;
                  default: begin
                     flush      = 1'b1;
                     flush_kind = KIND_ESC;
                  end
               endcase
            end
            MODE_CSI: begin
               if (req_data_byte >= BYTE_FINAL_LO && req_data_byte <= BYTE_FINAL_HI) begin
                  flush      = 1'b1;
                  flush_kind = KIND_CSI;
               end
            end
            MODE_SS3: begin
               if (len_inc >= LW'(3)) begin
                  flush      = 1'b1;
                  flush_kind = KIND_SS3;
               end
            end
            MODE_OSC, MODE_DCS: begin
               if (req_data_byte == BYTE_BEL ||
                   (pending_ff && req_data_byte == BYTE_BSLASH)) begin
                  flush      = 1'b1;
                  flush_kind = (mode_ff == MODE_OSC) ? KIND_OSC : KIND_DCS;
               end
               pending_in = (req_data_byte == BYTE_ESC);
            end
            default: begin
               mode_in   = MODE_IDLE;
               length_in = '0;
            end
         endcase
         // store full without an end: flush as overflow
         if (!flush && len_inc >= DEPTH_L) begin
            flush      = 1'b1;
            flush_kind = KIND_OVF;
         end
      end
   end

   // configuration register and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= '0;
         length_ff   <= '0;
         mode_ff     <= MODE_IDLE;
         utf8_len_ff <= '0;
         elapsed_ff  <= '0;
         pending_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) timeout_ff <= csr_wr_data;
         if (cmd.take) begin
            if (flush) begin
               length_ff   <= '0;
               mode_ff     <= MODE_IDLE;
               utf8_len_ff <= '0;
               elapsed_ff  <= '0;
               pending_ff  <= 1'b0;
            end else begin
               length_ff   <= length_in;
               mode_ff     <= mode_in;
               utf8_len_ff <= utf8_len_in;
               elapsed_ff  <= elapsed_in;
               pending_ff  <= pending_in;
            end
         end
      end
   end

   // readout bookkeeping, captured when a sequence completes
   always_ff @(posedge clock) begin
      if (cmd.take && flush) begin
         drain_len_ff <= (req_op == OP_TICK) ? length_ff : len_inc;
         kind_ff      <= flush_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
      end else if (cmd.take && flush) begin
         rd_ptr_ff <= '0;
      end else if (cmd.load) begin
         rd_ptr_ff <= rd_ptr_ff + AW'(1);
      end
   end

   // sequence store: write on byte transfer, registered read into the output
   always_ff @(posedge clock) begin
      if (cmd.take && req_op == OP_BYTE) begin
         store_mem[length_ff[AW-1:0]] <= req_data_byte;
      end
      if (cmd.load) begin
         rsp_byte_ff <= store_mem[rd_ptr_ff];
         rsp_kind_ff <= kind_ff;
         rsp_last_ff <= (LW'(rd_ptr_ff) + LW'(1) == drain_len_ff);
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seq_byte    = rsp_byte_ff;
   assign rsp_seq_kind    = rsp_kind_ff;
   assign rsp_last_of_seq = rsp_last_ff;

   // status to the controller
   always_comb begin
      status.flush_req  = flush;
      status.out_busy   = rsp_valid_ff && rsp_stall;
      status.drain_last = (LW'(rd_ptr_ff) + LW'(1) == drain_len_ff);
   end

   `TESF_ASSERT_NOW(a_read_in_range, clock, reset, cmd.load, LW'(rd_ptr_ff) < drain_len_ff, "readout past the end of the sequence")
   `TESF_ASSERT_NOW(a_store_not_full, clock, reset, 1'b1, length_ff < DEPTH_L, "held byte count reached the store depth")
   `TESF_ASSERT_NEXT(a_flush_clears, clock, reset, cmd.take && flush, length_ff == '0 && mode_ff == MODE_IDLE, "parser not cleared after a completed sequence")

endmodule

### rtl/terminal_escape_sequence_framer.sv
// Terminal escape sequence framer. Each accepted item (a byte or a timer tick) is taken
// whenever the input is not stalled. When an item completes a sequence of n bytes, the
// input is stalled while the sequence store is read out through its single read port,
// one byte per cycle while the result side does not stall; the last byte sits in the
// output register while the next item is already taken. Sequences that reach SEQ_DEPTH
// bytes without an end are flushed with the overflow kind. Reset is synchronous and
// needs no clearing pass; the timeout register reads zero after reset.
// depends on tesf_pkg, tesf_ctrl and tesf_datapath
module terminal_escape_sequence_framer
   import tesf_pkg::*;
#(
   parameter int SEQ_DEPTH = SEQ_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_seq_byte,
   output logic [2:0]  rsp_seq_kind,
   output logic        rsp_last_of_seq,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // handshake and readout sequencing
   tesf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, parser and output register
   tesf_datapath #(
      .SEQ_DEPTH (SEQ_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_seq_byte    (rsp_seq_byte),
      .rsp_seq_kind    (rsp_seq_kind),
      .rsp_last_of_seq (rsp_last_of_seq),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
